>>> src/assert_macros.svh
// Assertion macros shared by the RTL files; clocked on i_clk, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

>>> src/scc_pkg.sv
// Shared types, widths and helpers for the strongly connected components block.
`timescale 1ns / 1ps
package scc_pkg;
    localparam int VW    = 6;   // vertex number width
    localparam int RW    = 64;  // adjacency row width
    localparam int CNT_W = 7;   // vertex and component count width

    typedef struct packed {
        logic [VW-1:0] row;
        logic [RW-1:0] edges;
        logic          last_row;
    } t_in_beat;

    typedef struct packed {
        logic [VW-1:0]    vertex;
        logic [VW-1:0]    component;
        logic             component_end;
        logic             last;
        logic [CNT_W-1:0] component_total;
    } t_out_beat;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] component;
        logic          component_end;
    } t_res_entry;

    // Positions of a row whose index has bit b set.
    function automatic logic [RW-1:0] bit_select(input int b);
        logic [RW-1:0] sel;
        sel = '0;
        for (int p = 0; p < RW; p++) begin
            sel[p] = ((p >> b) & 1) == 1;
        end
        return sel;
    endfunction
endpackage

>>> src/scc_chan_if.sv
// Valid/ready channel carrying one beat of a given payload type.
`timescale 1ns / 1ps
interface scc_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/scc_pick.sv
// Candidate unit: lowest unvisited neighbour of a masked adjacency row.
`timescale 1ns / 1ps
module scc_pick (
    input  logic [scc_pkg::RW-1:0] i_row,
    input  logic [scc_pkg::RW-1:0] i_mask,
    input  logic [scc_pkg::RW-1:0] i_visited,
    output logic                   o_found,
    output logic [scc_pkg::VW-1:0] o_index
);
    import scc_pkg::*;

    logic [RW-1:0] w_cand;
    logic [RW-1:0] w_low;

    assign w_cand  = i_row & i_mask & ~i_visited;
    // isolate the lowest set bit
    assign w_low   = w_cand & (~w_cand + RW'(1));
    assign o_found = |w_cand;

    always_comb begin
        for (int b = 0; b < VW; b++) begin
            o_index[b] = |(w_low & bit_select(b));
        end
    end
endmodule

>>> src/strongly_connected_components.sv
// Sequence: rows are stored as they arrive while idle; after the last row a first
//   depth-first pass records finishing order, the transpose is built column by column,
//   a second pass walks it in reverse finishing order, then result beats go to the sink.
// Throughput: one search at a time; the adjacency memory's single read port and the
//   shared candidate unit set the pace. Input is refused from the last row until the
//   final result beat is taken. Synchronous active-low reset clears control state.
`timescale 1ns / 1ps
module strongly_connected_components #(
    parameter int MAX_VERTS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [scc_pkg::CNT_W-1:0] i_cfg_data,
    scc_chan_if.sink                  i_in,
    scc_chan_if.source                o_res
);
    import scc_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;  // memory index width
    localparam int CW = $clog2(MAX_VERTS + 1);                    // counter width
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_VERTS);

    // Sequencer states, one-hot.
    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_P1_ROOT  = 12'b0000_0000_0010,  // pick next first-pass root
        S_WALK_RD  = 12'b0000_0000_0100,  // graph row read for stack top
        S_WALK_EV  = 12'b0000_0000_1000,  // push neighbour or pop
        S_STK_WAIT = 12'b0000_0001_0000,  // new stack top from memory
        S_TR_RD    = 12'b0000_0010_0000,  // transpose: read row r
        S_TR_EV    = 12'b0000_0100_0000,  // transpose: gather bit j of row r
        S_P2_ROOT  = 12'b0000_1000_0000,  // pop finishing order
        S_P2_WAIT  = 12'b0001_0000_0000,  // start a component walk or skip a visited vertex
        S_OUT_RD   = 12'b0010_0000_0000,
        S_OUT_LOAD = 12'b0100_0000_0000,
        S_OUT_HOLD = 12'b1000_0000_0000
    } t_state;

    // Memories: read data registered, one write port each.
    logic [RW-1:0] adj_mem [MAX_VERTS];
    logic [RW-1:0] rev_mem [MAX_VERTS];
    logic [VW-1:0] stk_mem [MAX_VERTS];
    logic [VW-1:0] fin_mem [MAX_VERTS];
    t_res_entry    res_mem [MAX_VERTS];

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_vcount;
    logic             r_pass2, n_pass2;
    logic [RW-1:0]    r_visited, n_visited;
    logic [CW-1:0]    r_depth, n_depth;
    logic [CW-1:0]    r_fc, n_fc;
    logic [CW-1:0]    r_r, n_r;
    logic [CW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_k, n_k;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_comp, n_comp;
    logic [CW-1:0]    r_i, n_i;
    logic [VW-1:0]    r_top, n_top;
    logic [VW-1:0]    r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    logic [RW-1:0]    r_acc, n_acc;
    logic             r_out_v, n_out_v;
    t_out_beat        r_out, n_out;

    logic [RW-1:0] r_adj_rd, r_rev_rd;
    logic [VW-1:0] r_stk_rd, r_fin_rd;
    t_res_entry    r_res_rd;

    logic [CNT_W-1:0] w_n7;
    logic [CW-1:0]    w_n;
    logic [RW-1:0]    w_mask;
    logic [IW-1:0]    w_adj_ra;
    logic             w_found;
    logic [VW-1:0]    w_pick;

    // memory write controls
    logic             w_adj_we, w_rev_we, w_stk_we, w_fin_we, w_res_we;
    logic [IW-1:0]    w_adj_wa, w_rev_wa, w_stk_wa, w_fin_wa, w_res_wa;
    logic [RW-1:0]    w_adj_wd;
    logic [RW-1:0]    w_rev_wd;
    logic [VW-1:0]    w_stk_wd;
    t_res_entry       w_res_wd;

    // Active vertex count: zero counts as one, clamp at the vertex capacity.
    always_comb begin
        if (r_vcount == '0) begin
            w_n7 = CNT_W'(1);
        end else if (r_vcount > MAX_N) begin
            w_n7 = MAX_N;
        end else begin
            w_n7 = r_vcount;
        end
    end
    assign w_n = CW'(w_n7);

    always_comb begin
        for (int c = 0; c < RW; c++) begin
            w_mask[c] = CNT_W'(c) < w_n7;
        end
    end

    // Shared candidate unit, fed by whichever graph the current pass walks.
    scc_pick u_pick (
        .i_row     (r_pass2 ? r_rev_rd : r_adj_rd),
        .i_mask    (w_mask),
        .i_visited (r_visited),
        .o_found   (w_found),
        .o_index   (w_pick)
    );

    assign w_adj_ra = (r_state == S_TR_RD) ? r_r[IW-1:0] : r_top[IW-1:0];

    always_ff @(posedge i_clk) begin
        r_adj_rd <= adj_mem[w_adj_ra];
        r_rev_rd <= rev_mem[r_top[IW-1:0]];
        r_stk_rd <= stk_mem[IW'(r_depth - CW'(2))];
        r_fin_rd <= fin_mem[IW'(r_k - CW'(1))];
        r_res_rd <= res_mem[r_i[IW-1:0]];
        if (w_adj_we) adj_mem[w_adj_wa] <= w_adj_wd;
        if (w_rev_we) rev_mem[w_rev_wa] <= w_rev_wd;
        if (w_stk_we) stk_mem[w_stk_wa] <= w_stk_wd;
        if (w_fin_we) fin_mem[w_fin_wa] <= r_top;
        if (w_res_we) res_mem[w_res_wa] <= w_res_wd;
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_res.valid   = r_out_v;
    assign o_res.payload = r_out;

    always_comb begin
        logic          push;
        logic [VW-1:0] push_v;
        n_state   = r_state;
        n_pass2   = r_pass2;
        n_visited = r_visited;
        n_depth   = r_depth;
        n_fc      = r_fc;
        n_r       = r_r;
        n_j       = r_j;
        n_k       = r_k;
        n_count   = r_count;
        n_comp    = r_comp;
        n_i       = r_i;
        n_top     = r_top;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_acc     = r_acc;
        n_out_v   = r_out_v;
        n_out     = r_out;
        push      = 1'b0;
        push_v    = r_top;
        w_adj_we  = 1'b0;
        w_adj_wa  = i_in.payload.row[IW-1:0];
        w_adj_wd  = i_in.payload.edges & w_mask;
        w_rev_we  = 1'b0;
        w_rev_wa  = r_j[IW-1:0];
        w_rev_wd  = r_acc;
        w_fin_we  = 1'b0;
        w_fin_wa  = r_fc[IW-1:0];
        w_res_we  = 1'b0;
        w_res_wa  = IW'(r_count - CW'(1));
        w_res_wd  = '{vertex: r_pend, component: VW'(r_comp), component_end: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // store rows inside the active count only
                    w_adj_we = {1'b0, i_in.payload.row} < w_n7;
                    if (i_in.payload.last_row) begin
                        n_visited = '0;
                        n_fc      = '0;
                        n_r       = '0;
                        n_depth   = '0;
                        n_pass2   = 1'b0;
                        n_state   = S_P1_ROOT;
                    end
                end
            end
            S_P1_ROOT: begin
                if (r_r == w_n) begin
                    n_r     = '0;
                    n_j     = '0;
                    n_acc   = '0;
                    n_state = S_TR_RD;
                end else if (r_visited[VW'(r_r)]) begin
                    n_r = r_r + CW'(1);
                end else begin
                    push    = 1'b1;
                    push_v  = VW'(r_r);
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                n_state = S_WALK_EV;
            end
            S_WALK_EV: begin
                if (w_found) begin
                    push    = 1'b1;
                    push_v  = w_pick;
                    n_state = S_WALK_RD;
                end else begin
                    n_depth = r_depth - CW'(1);
                    if (!r_pass2) begin
                        w_fin_we = 1'b1;
                        n_fc     = r_fc + CW'(1);
                    end
                    if (r_depth == CW'(1)) begin
                        if (r_pass2) begin
                            // close the component on its last discovered vertex
                            w_res_we = 1'b1;
                            w_res_wd.component_end = 1'b1;
                            n_pend_v = 1'b0;
                            n_comp   = r_comp + CW'(1);
                            n_state  = S_P2_ROOT;
                        end else begin
                            n_r     = r_r + CW'(1);
                            n_state = S_P1_ROOT;
                        end
                    end else begin
                        n_state = S_STK_WAIT;
                    end
                end
            end
            S_STK_WAIT: begin
                n_top   = r_stk_rd;
                n_state = S_WALK_RD;
            end
            S_TR_RD: begin
                n_state = S_TR_EV;
            end
            S_TR_EV: begin
                n_acc[VW'(r_r)] = r_adj_rd[VW'(r_j)];
                if (r_r == w_n - CW'(1)) begin
                    // column complete, including the bit gathered this cycle
                    w_rev_we = 1'b1;
                    w_rev_wd = n_acc;
                    n_acc    = '0;
                    n_r      = '0;
                    if (r_j == w_n - CW'(1)) begin
                        n_pass2   = 1'b1;
                        n_visited = '0;
                        n_k       = r_fc;
                        n_count   = '0;
                        n_comp    = '0;
                        n_pend_v  = 1'b0;
                        n_depth   = '0;
                        n_state   = S_P2_ROOT;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_TR_RD;
                    end
                end else begin
                    n_r     = r_r + CW'(1);
                    n_state = S_TR_RD;
                end
            end
            S_P2_ROOT: begin
                if (r_k == '0) begin
                    n_i     = '0;
                    n_state = (r_count != '0) ? S_OUT_RD : S_IDLE;
                end else begin
                    n_k     = r_k - CW'(1);
                    n_state = S_P2_WAIT;
                end
            end
            S_P2_WAIT: begin
                if ({1'b0, r_fin_rd} >= w_n7 || r_visited[r_fin_rd]) begin
                    n_state = S_P2_ROOT;
                end else begin
                    push    = 1'b1;
                    push_v  = r_fin_rd;
                    n_state = S_WALK_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                n_out_v                 = 1'b1;
                n_out.vertex            = r_res_rd.vertex;
                n_out.component         = r_res_rd.component;
                n_out.component_end     = r_res_rd.component_end;
                n_out.last              = (r_i == r_count - CW'(1));
                n_out.component_total   = n_out.last ? CNT_W'(r_comp) : '0;
                n_state                 = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (o_res.ready) begin
                    n_out_v = 1'b0;
                    n_i     = r_i + CW'(1);
                    n_state = r_out.last ? S_IDLE : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Push: mark visited, place on the stack, record discovery in the second pass.
        if (push) begin
            n_visited         = n_visited | (RW'(1) << push_v);
            n_depth           = r_depth + CW'(1);
            n_top             = push_v;
            if (r_pass2) begin
                w_res_we = r_pend_v;
                n_pend   = push_v;
                n_pend_v = 1'b1;
                n_count  = r_count + CW'(1);
            end
        end
        w_stk_we = push;
        w_stk_wa = r_depth[IW-1:0];
        w_stk_wd = push_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= CNT_W'(7);
            r_pass2  <= 1'b0;
            r_depth  <= '0;
            r_fc     <= '0;
            r_r      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_count  <= '0;
            r_comp   <= '0;
            r_i      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_visited <= '0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) r_vcount <= i_cfg_data;
            r_pass2   <= n_pass2;
            r_depth   <= n_depth;
            r_fc      <= n_fc;
            r_r       <= n_r;
            r_j       <= n_j;
            r_k       <= n_k;
            r_count   <= n_count;
            r_comp    <= n_comp;
            r_i       <= n_i;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
            r_visited <= n_visited;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_pend <= n_pend;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    `ASSERT_ALWAYS(a_depth_bound, r_depth <= CW'(MAX_VERTS), "walk stack overflow")
    `ASSERT_IMPLIES(a_out_state, r_out_v, r_state == S_OUT_HOLD, "result beat outside hold")
    `ASSERT_IMPLIES(a_done, r_out_v & o_res.ready & r_out.last, ##1 i_in.ready, "stuck after last")
    `ASSERT_IMPLIES(a_comp_count, r_state == S_OUT_HOLD, r_comp <= r_count, "too many components")
endmodule
